// ===== rtl/stas_pkg.sv =====
// Shared types, constants and the arctangent table for the spinning target armor selector.
package stas_pkg;

  localparam int POS_W     = 24;
  localparam int SPIN_W    = 16;
  localparam int CNT_W     = 3;
  localparam int ANGLE_W   = 16;
  localparam int IDX_W     = 2;
  localparam int YAW_N     = 4;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_ARMORS_DEF = 4;

  // cordic: 24-bit input, one half-turn pre-rotation and gain of ~1.65 fit in 27 bits
  localparam int CW        = 27;
  localparam int STEPS     = 15;
  localparam int STEP_W    = 4;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

  // stream packing
  localparam int S_TDATA_W = 136;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 8;
  localparam int M_TUSER_W = 1;
  localparam int CX_LSB    = 0;
  localparam int CY_LSB    = CX_LSB + POS_W;
  localparam int SPIN_LSB  = CY_LSB + POS_W;
  localparam int CNT_LSB   = SPIN_LSB + SPIN_W;
  localparam int YAW_LSB   = CNT_LSB + CNT_W;
  localparam int USER_JUMPED  = 0;
  localparam int USER_OUTPOST = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COMING  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LEAVING = CFG_IDX_W'(1);

  localparam logic [ANGLE_W-1:0] COMING_RST      = 16'd10923;
  localparam logic [ANGLE_W-1:0] LEAVING_RST     = 16'd3641;
  localparam logic [ANGLE_W-1:0] SLOW_WINDOW     = 16'd10922;
  localparam logic [ANGLE_W-1:0] OUTPOST_COMING  = 16'd12742;
  localparam logic [ANGLE_W-1:0] OUTPOST_LEAVING = 16'd5461;
  localparam logic [ANGLE_W-1:0] HALF_TURN       = 16'h8000;
  localparam logic signed [SPIN_W-1:0] SLOW_SPIN = 16'sd512;

  typedef struct packed {
    logic              load;
    logic              rotate;
    logic              delta;
    logic              decide;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  // atan(2^-i) in binary angle units
  function automatic logic [ANGLE_W-1:0] atan_tab(input logic [STEP_W-1:0] i);
    logic [ANGLE_W-1:0] v;
    case (i)
      4'd0:    v = 16'd8192;
      4'd1:    v = 16'd4836;
      4'd2:    v = 16'd2555;
      4'd3:    v = 16'd1297;
      4'd4:    v = 16'd651;
      4'd5:    v = 16'd326;
      4'd6:    v = 16'd163;
      4'd7:    v = 16'd81;
      4'd8:    v = 16'd41;
      4'd9:    v = 16'd20;
      4'd10:   v = 16'd10;
      4'd11:   v = 16'd5;
      4'd12:   v = 16'd3;
      4'd13:   v = 16'd1;
      4'd14:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/stas_ctrl.sv =====
// Sequencer: accept, cordic steps, armor deltas, decision.
module stas_ctrl import stas_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ROTATE = 4'b0010,
    S_DELTA  = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] step;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.step   = step;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_ROTATE;
        end
      end
      S_ROTATE: begin
        cmd.rotate = 1'b1;
        if (step == STEP_LAST) begin
          state_next = S_DELTA;
        end
      end
      S_DELTA: begin
        cmd.delta  = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.out_free) begin
          cmd.decide = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (cmd.load || (cmd.rotate && step == STEP_LAST)) begin
        step <= '0;
      end else if (cmd.rotate) begin
        step <= step + STEP_W'(1);
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_ROTATE && step == '0))
    else $error("accepted word did not start rotation at step 0");

  a_rotate_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROTATE && step == STEP_LAST) |=> (state == S_DELTA))
    else $error("last cordic step not followed by delta");

  a_decide_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && !sts.out_free) |=> (state == S_DECIDE && !in_ready))
    else $error("decision left while output register busy");

endmodule

// ===== rtl/stas_dp.sv =====
// Datapath: input registers, shared cordic step, armor deltas, selection, lock and output register.
module stas_dp import stas_pkg::*; #(
  parameter int MAX_ARMORS = MAX_ARMORS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [ANGLE_W-1:0]       cfg_data,
  input  logic signed [POS_W-1:0]  center_x,
  input  logic signed [POS_W-1:0]  center_y,
  input  logic signed [SPIN_W-1:0] spin_rate,
  input  logic [CNT_W-1:0]         armor_count,
  input  logic [ANGLE_W-1:0]       armor_yaw [YAW_N],
  input  logic                     jumped,
  input  logic                     is_outpost,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     valid_res,
  output logic [IDX_W-1:0]         armor_index
);

  logic [ANGLE_W-1:0] approach_win, depart_win;

  logic signed [CW-1:0] x, y;
  logic [ANGLE_W-1:0]   z;
  logic                 zero_vec;
  logic signed [SPIN_W-1:0] spin;
  logic [CNT_W-1:0]     cnt;
  logic                 jumped_r, outpost_r;
  logic [ANGLE_W-1:0]   yaw   [MAX_ARMORS];
  logic [ANGLE_W-1:0]   delta [MAX_ARMORS];
  logic [ANGLE_W-1:0]   mag   [MAX_ARMORS];
  logic [MAX_ARMORS-1:0] lane_en;

  logic                 lock_present;
  logic [IDX_W-1:0]     locked_armor;

  // load
  logic signed [CW-1:0] x_in, y_in;
  logic [CNT_W-1:0]     cnt_in;
  // cordic step
  logic signed [CW-1:0] xs, ys, x_next, y_next;
  logic [ANGLE_W-1:0]   z_next, bearing;
  // decision
  logic                 slow, spin_pos, spin_neg, found;
  logic [ANGLE_W-1:0]   com, lea;
  logic signed [ANGLE_W+1:0] lea_s, lea_neg, d_s;
  logic [1:0]           n;
  logic [IDX_W-1:0]     c0, c1, fast_idx;
  logic [ANGLE_W-1:0]   a0, a1;
  logic                 valid_next, lock_present_next;
  logic [IDX_W-1:0]     idx_next, locked_armor_next;

  assign sts.out_free = !out_valid || out_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      approach_win <= COMING_RST;
      depart_win   <= LEAVING_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COMING:  approach_win <= cfg_data;
        REG_LEAVING: depart_win   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    x_in   = {{(CW-POS_W){center_x[POS_W-1]}}, center_x};
    y_in   = {{(CW-POS_W){center_y[POS_W-1]}}, center_y};
    cnt_in = (armor_count > CNT_W'(MAX_ARMORS)) ? CNT_W'(MAX_ARMORS) : armor_count;
  end

  always_comb begin
    xs = x >>> cmd.step;
    ys = y >>> cmd.step;
    if (!y[CW-1] && (y != '0)) begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + atan_tab(cmd.step);
    end else begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - atan_tab(cmd.step);
    end
    bearing = zero_vec ? '0 : z;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      zero_vec  <= (center_x == '0) && (center_y == '0);
      if (center_x[POS_W-1]) begin
        x <= -x_in;
        y <= -y_in;
        z <= HALF_TURN;
      end else begin
        x <= x_in;
        y <= y_in;
        z <= '0;
      end
      spin      <= spin_rate;
      cnt       <= cnt_in;
      jumped_r  <= jumped;
      outpost_r <= is_outpost;
      for (int i = 0; i < MAX_ARMORS; i++) begin
        yaw[i] <= armor_yaw[i];
      end
    end else if (cmd.rotate) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
    if (cmd.delta) begin
      for (int i = 0; i < MAX_ARMORS; i++) begin
        delta[i]   <= yaw[i] - bearing;
        mag[i]     <= ((yaw[i] - bearing) >= HALF_TURN) ? bearing - yaw[i] : yaw[i] - bearing;
        lane_en[i] <= CNT_W'(i) < cnt;
      end
    end
  end

  always_comb begin
    slow     = (spin <= SLOW_SPIN) && (spin >= -SLOW_SPIN) && !outpost_r;
    spin_pos = !spin[SPIN_W-1] && (spin != '0);
    spin_neg = spin[SPIN_W-1];
    com      = outpost_r ? OUTPOST_COMING : approach_win;
    lea      = outpost_r ? OUTPOST_LEAVING : depart_win;
    lea_s    = {2'b00, lea};
    lea_neg  = -lea_s;

    // first two armors inside the slow window
    n  = 2'd0;
    c0 = '0;
    c1 = '0;
    a0 = '0;
    a1 = '0;
    for (int i = 0; i < MAX_ARMORS; i++) begin
      if (lane_en[i] && mag[i] <= SLOW_WINDOW) begin
        if (n == 2'd0) begin
          c0 = IDX_W'(i);
          a0 = mag[i];
          n  = 2'd1;
        end else if (n == 2'd1) begin
          c1 = IDX_W'(i);
          a1 = mag[i];
          n  = 2'd2;
        end
      end
    end

    // first armor inside the coming window that is not leaving
    found    = 1'b0;
    fast_idx = '0;
    for (int i = 0; i < MAX_ARMORS; i++) begin
      d_s = {{2{delta[i][ANGLE_W-1]}}, delta[i]};
      if (!found && lane_en[i] && mag[i] <= com &&
          ((spin_pos && d_s < lea_s) || (spin_neg && d_s > lea_neg))) begin
        found    = 1'b1;
        fast_idx = IDX_W'(i);
      end
    end

    valid_next        = 1'b0;
    idx_next          = '0;
    lock_present_next = lock_present;
    locked_armor_next = locked_armor;
    if (cnt == '0) begin
      valid_next = 1'b0;
    end else if (!jumped_r) begin
      valid_next = 1'b1;
    end else if (slow) begin
      if (n == 2'd1) begin
        lock_present_next = 1'b0;
        locked_armor_next = '0;
        valid_next        = 1'b1;
        idx_next          = c0;
      end else if (n == 2'd2) begin
        if (!lock_present || (locked_armor != c0 && locked_armor != c1)) begin
          locked_armor_next = (a0 < a1) ? c0 : c1;
          lock_present_next = 1'b1;
        end
        valid_next = 1'b1;
        idx_next   = locked_armor_next;
      end
    end else begin
      valid_next = found;
      idx_next   = fast_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_present <= 1'b0;
      locked_armor <= '0;
      out_valid    <= 1'b0;
    end else if (cmd.decide) begin
      lock_present <= lock_present_next;
      locked_armor <= locked_armor_next;
      out_valid    <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      valid_res   <= valid_next;
      armor_index <= valid_next ? idx_next : '0;
    end
  end

  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !valid_res) |-> (armor_index == '0))
    else $error("invalid result carries nonzero armor index");

  a_lock_range: assert property (@(posedge clk) disable iff (rst)
    lock_present |-> (int'(locked_armor) < MAX_ARMORS))
    else $error("locked armor out of range");

  a_lock_on_decide: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (lock_present != $past(lock_present) ||
                     locked_armor != $past(locked_armor))) |-> $past(cmd.decide))
    else $error("lock changed outside a decision");

endmodule

// ===== rtl/spinning_target_armor_select_unit.sv =====
// Top level of the spinning target armor selector.
//
// Input stream (s_axis): one word per camera frame with the target center, spin
// rate, armor count and up to four armor yaw angles; tuser carries the jumped and
// outpost flags. Output stream (m_axis): one word per input word; tuser is the
// valid bit, tdata the chosen armor index (0 when not valid).
// Configuration: cfg_we writes cfg_data into register cfg_index (0 coming
// window, 1 leaving cut-off); writes to other indexes are dropped.
// Sequence: the center bearing comes from a 15-step cordic that reuses one
// shift-add stage, followed by a delta state and a decision state. A new word is
// taken only once the previous word has left its decision state.
// While a result waits for m_axis_tready the next word is still accepted and
// processed; it holds in its decision cycle until the output register is free.
// Reset clears the armor lock and the output valid flag and restores the register
// defaults.
module spinning_target_armor_select_unit import stas_pkg::*; #(
  parameter int MAX_ARMORS = MAX_ARMORS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // center_x, center_y, spin_rate, armor_count, armor_yaw_0..3, zero fill
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // jumped, is_outpost
  input  logic [S_TUSER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // armor_index, zero fill
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // valid_res
  output logic [M_TUSER_W-1:0]  m_axis_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ANGLE_W-1:0]    cfg_data
);

  cmd_t               cmd;
  sts_t               sts;
  logic [ANGLE_W-1:0] yaw [YAW_N];
  logic               valid_res;
  logic [IDX_W-1:0]   armor_index;

  always_comb begin
    for (int i = 0; i < YAW_N; i++) begin
      yaw[i] = s_axis_tdata[YAW_LSB + i*ANGLE_W +: ANGLE_W];
    end
  end

  stas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stas_dp #(
    .MAX_ARMORS (MAX_ARMORS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .center_x    ($signed(s_axis_tdata[CX_LSB +: POS_W])),
    .center_y    ($signed(s_axis_tdata[CY_LSB +: POS_W])),
    .spin_rate   ($signed(s_axis_tdata[SPIN_LSB +: SPIN_W])),
    .armor_count (s_axis_tdata[CNT_LSB +: CNT_W]),
    .armor_yaw   (yaw),
    .jumped      (s_axis_tuser[USER_JUMPED]),
    .is_outpost  (s_axis_tuser[USER_OUTPOST]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .valid_res   (valid_res),
    .armor_index (armor_index)
  );

  assign m_axis_tdata = {{(M_TDATA_W-IDX_W){1'b0}}, armor_index};
  assign m_axis_tuser = valid_res;

endmodule
